/* rtl/core/lsws_pkg.sv */
// Shared types and constants for the LIFO stack with search.
`default_nettype none
package lsws_pkg;

    localparam int DEPTH = 8;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_LIST   = 2'd2,
        FUNC_SEARCH = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_OVERFLOW  = 2'd1,
        STAT_UNDERFLOW = 2'd2,
        STAT_EMPTY     = 2'd3
    } status_t;

    // Shift commands broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic rot;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/lsws_cell.sv */
// One storage cell of the stack chain: holds a word, shifts with its neighbors.
`default_nettype none
module lsws_cell (
    input  wire logic               aclk,
    input  wire lsws_pkg::cell_ctrl_t ctrl,
    input  wire lsws_pkg::word_t    word_above,
    input  wire lsws_pkg::word_t    word_below,
    input  wire lsws_pkg::word_t    word_top,
    input  wire logic               is_bottom,
    input  wire logic               occupied,
    input  wire lsws_pkg::word_t    key,
    output lsws_pkg::word_t         word,
    output logic                    match
);
    import lsws_pkg::*;

    word_t word_reg;
    word_t word_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.push) begin
            word_next = word_above;
        end else if (ctrl.pop) begin
            word_next = word_below;
        end else if (ctrl.rot) begin
            // bottom cell closes the ring by taking the top word
            word_next = is_bottom ? word_top : word_below;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word  = word_reg;
    assign match = occupied && (word_reg == key);

endmodule
`default_nettype wire

/* rtl/core/lifo_stack_with_search.sv */
// Top level of the LIFO stack with search: control, fill count and output register.
//
// Bounded LIFO stack of signed 32-bit words held in a chain of DEPTH cells,
// cell 0 being the top of stack. Each input item carries an operation in
// s_tuser (push, pop, list, search) and a word in s_tdata. Push shifts the
// whole chain down by one and drops the new word into cell 0; pop shifts it
// up and returns the old top word. Search compares the key against every
// occupied cell in parallel and ORs the hits. List rotates the occupied part
// of the chain up by one cell per cycle while the output register is free,
// the bottom occupied cell taking the top word, and emits cell 0 each time;
// after fill-count rotations the chain is back where it started. Push, pop
// and search give one result each; a list gives one result per stored word,
// held back only by back-pressure on m_tready, and keeps the input closed
// until the last word is emitted. One result sits in the output register; a
// new item is accepted while that result is taken. Push on a full stack
// reports overflow, pop on an empty stack underflow, list on an empty stack
// a single empty result. No reset sweep is needed.
`default_nettype none
module lifo_stack_with_search (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    input  wire logic [1:0]  s_tuser,   // [1:0] func
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] data
    output logic [2:0]       m_tuser,   // [1:0] status, [2] found
    output logic             m_tlast
);
    import lsws_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LIST = 2'b10
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] step_reg, step_next;

    logic            m_valid_reg, m_valid_next;
    word_t           m_data_reg, m_data_next;
    status_t         m_status_reg, m_status_next;
    logic            m_found_reg, m_found_next;
    logic            m_last_reg, m_last_next;

    cell_ctrl_t      ctrl;
    word_t           words [DEPTH];
    logic [DEPTH-1:0] hit_vec;
    word_t           key;
    func_t           func;

    logic out_free;
    logic in_fire;
    logic full;
    logic empty;
    logic list_last;

    assign key       = word_t'(s_tdata);
    assign func      = func_t'(s_tuser);
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = (step_reg == count_reg - CNT_W'(1));

    // Chain of storage cells, cell 0 on top.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        word_t above;
        word_t below;
        if (i == 0) begin : g_first
            assign above = key;
        end else begin : g_mid
            assign above = words[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign below = '0;
        end else begin : g_inner
            assign below = words[i+1];
        end
        lsws_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .word_above (above),
            .word_below (below),
            .word_top   (words[0]),
            .is_bottom  (count_reg == CNT_W'(i + 1)),
            .occupied   (CNT_W'(i) < count_reg),
            .key        (key),
            .word       (words[i]),
            .match      (hit_vec[i])
        );
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        step_next     = step_reg;
        ctrl          = '0;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_status_next = m_status_reg;
        m_found_next  = m_found_reg;
        m_last_next   = m_last_reg;

        if (in_fire) begin
            // default result: ok, zero data, single item
            m_valid_next  = 1'b1;
            m_data_next   = '0;
            m_status_next = STAT_OK;
            m_found_next  = 1'b0;
            m_last_next   = 1'b1;
            case (func)
                FUNC_PUSH: begin
                    if (full) begin
                        m_status_next = STAT_OVERFLOW;
                    end else begin
                        ctrl.push  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                FUNC_POP: begin
                    if (empty) begin
                        m_status_next = STAT_UNDERFLOW;
                    end else begin
                        ctrl.pop    = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                        m_data_next = words[0];
                    end
                end
                FUNC_LIST: begin
                    if (empty) begin
                        m_status_next = STAT_EMPTY;
                    end else begin
                        // results come from the walk, none now
                        m_valid_next = 1'b0;
                        state_next   = ST_LIST;
                        step_next    = '0;
                    end
                end
                FUNC_SEARCH: begin
                    m_found_next = |hit_vec;
                end
                default: begin
                    m_status_next = STAT_OK;
                end
            endcase
        end else if (state_reg == ST_LIST && out_free) begin
            // emit the top word and rotate the occupied part of the chain
            ctrl.rot      = 1'b1;
            m_valid_next  = 1'b1;
            m_data_next   = words[0];
            m_status_next = STAT_OK;
            m_found_next  = 1'b0;
            m_last_next   = list_last;
            if (list_last) begin
                state_next = ST_IDLE;
            end else begin
                step_next = step_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg   <= m_data_next;
        m_status_reg <= m_status_next;
        m_found_reg  <= m_found_next;
        m_last_reg   <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = {m_found_reg, m_status_reg};
    assign m_tlast  = m_last_reg;

    // Fill count never goes past the number of cells.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // A walk only runs over a non-empty stack and stays within it.
    a_list_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> (!empty && step_reg < count_reg))
        else $error("list walk out of range");

    // A successful push grows the stack by exactly one.
    a_push_grow: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && func == FUNC_PUSH && !full) |=>
            (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("push did not grow stack");

    // A list walk leaves the fill count untouched.
    a_list_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |=> $stable(count_reg))
        else $error("fill count changed during list");

    // The input side stays closed while a walk runs.
    a_list_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LIST) |-> !s_tready)
        else $error("input open during list");

endmodule
`default_nettype wire
